>>> sv/sliding_window_vote_filter_top_assert.svh
// Assertion macros shared by the vote filter modules.
// Expands to concurrent assertions in simulation and to nothing under synthesis.
`ifndef SLIDING_WINDOW_VOTE_FILTER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_VOTE_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define SWVF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vote filter assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define SWVF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vote filter assertion failed");
`else
`define SWVF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SWVF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/swvf_pkg.sv
// Package for the sliding window vote filter: sizes, codes, payload and control types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package swvf_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int PTR_BITS   = $clog2(WINDOW_MAX);
   localparam int CNT_BITS   = 5;
   localparam int CONF_BITS  = 16;
   localparam int SUM_BITS   = 20;
   localparam int DIR_BITS   = 2;
   localparam int DIR_COUNT  = 4;
   localparam int DIV_STEPS  = SUM_BITS;
   localparam int IDX_BITS   = 1;

   localparam logic [CNT_BITS-1:0] WINDOW_RESET   = 5'd5;
   localparam logic [CNT_BITS-1:0] MIN_VOTES_RESET = 5'd3;

   localparam logic [IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
   localparam logic [IDX_BITS-1:0] REG_MIN_VOTES     = 1'b1;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [DIR_BITS-1:0]  vote_direction;
      logic [CONF_BITS-1:0] vote_confidence;
   } req_type;

   typedef struct packed {
      logic [DIR_BITS-1:0]  winner_direction;
      logic [CNT_BITS-1:0]  winner_votes;
      logic                 is_stable;
      logic [CONF_BITS-1:0] mean_confidence;
   } rsp_type;

   typedef struct packed {
      logic [DIR_BITS-1:0]  dir;
      logic [CONF_BITS-1:0] conf;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_TALLY,
      ST_SETTLE,
      ST_PICK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                capture;
      logic                commit;
      logic                read;
      logic [PTR_BITS-1:0] rd_idx;
      logic                pick;
      logic                div_step;
      logic                load_out;
   } cmd_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] fill;
   } status_type;

endpackage

>>> sv/swvf_datapath.sv
// Datapath of the vote filter: settings, vote ring, tallies, winner pick, divider, output register.
// Depends on swvf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sliding_window_vote_filter_top_assert.svh"

module swvf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swvf_pkg::cmd_type                    cmd,
   output swvf_pkg::status_type                 status,
   input  swvf_pkg::req_type                    req_data,
   output swvf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [swvf_pkg::IDX_BITS-1:0]        csr_index,
   input  logic [swvf_pkg::CNT_BITS-1:0]        csr_wdata
);

   logic [swvf_pkg::CNT_BITS-1:0]  window_ff;
   logic [swvf_pkg::CNT_BITS-1:0]  min_votes_ff;
   swvf_pkg::req_type              req_ff;
   swvf_pkg::slot_type             ring_mem [swvf_pkg::WINDOW_MAX];
   swvf_pkg::slot_type             rd_data_ff;
   logic                           rd_valid_ff;
   logic [swvf_pkg::PTR_BITS-1:0]  head_ff;
   logic [swvf_pkg::CNT_BITS-1:0]  fill_ff;
   logic [swvf_pkg::CNT_BITS-1:0]  tally_ff [swvf_pkg::DIR_COUNT];
   logic [swvf_pkg::SUM_BITS-1:0]  total_ff [swvf_pkg::DIR_COUNT];
   logic [swvf_pkg::DIR_BITS-1:0]  best_dir_ff;
   logic [swvf_pkg::CNT_BITS-1:0]  best_votes_ff;
   logic                           stable_ff;
   logic [swvf_pkg::SUM_BITS-1:0]  div_quo_ff;
   logic [swvf_pkg::CNT_BITS-1:0]  div_rem_ff;
   swvf_pkg::rsp_type              rsp_ff;

   logic [swvf_pkg::CNT_BITS-1:0]  win_eff;
   logic [swvf_pkg::CNT_BITS-1:0]  fill_inc;
   logic [swvf_pkg::PTR_BITS-1:0]  rd_addr;
   logic [swvf_pkg::DIR_BITS-1:0]  best_in;
   logic [swvf_pkg::CNT_BITS:0]    div_shift;
   logic                           div_ge;
   logic [swvf_pkg::CNT_BITS:0]    div_diff;

   // Clamp the window length to 1..WINDOW_MAX.
   always_comb begin
      if (window_ff == '0) begin
         win_eff = swvf_pkg::CNT_BITS'(1);
      end else if (window_ff > swvf_pkg::CNT_BITS'(swvf_pkg::WINDOW_MAX)) begin
         win_eff = swvf_pkg::CNT_BITS'(swvf_pkg::WINDOW_MAX);
      end else begin
         win_eff = window_ff;
      end
      fill_inc = fill_ff + swvf_pkg::CNT_BITS'(1);
      rd_addr  = head_ff - swvf_pkg::PTR_BITS'(1) - cmd.rd_idx;
   end

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swvf_pkg::WINDOW_RESET;
         min_votes_ff <= swvf_pkg::MIN_VOTES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            swvf_pkg::REG_WINDOW_LENGTH: window_ff    <= csr_wdata;
            swvf_pkg::REG_MIN_VOTES:     min_votes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ring pointer and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read;
         if (cmd.commit) begin
            if (req_ff.mode == swvf_pkg::MODE_CLEAR) begin
               fill_ff <= '0;
            end else begin
               head_ff <= head_ff + swvf_pkg::PTR_BITS'(1);
               fill_ff <= (fill_inc > win_eff) ? win_eff : fill_inc;
            end
         end
      end
   end

   // Request latch and vote ring; read data registered.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit && req_ff.mode == swvf_pkg::MODE_ADD) begin
         ring_mem[head_ff] <= '{dir: req_ff.vote_direction, conf: req_ff.vote_confidence};
      end
      if (cmd.read) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // Tallies: clear on commit, accumulate one ring entry per cycle; direction 0 entries are not counted.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int d = 0; d < swvf_pkg::DIR_COUNT; d++) begin
            tally_ff[d] <= '0;
            total_ff[d] <= '0;
         end
      end else if (rd_valid_ff && rd_data_ff.dir != '0) begin
         tally_ff[rd_data_ff.dir] <= tally_ff[rd_data_ff.dir] + swvf_pkg::CNT_BITS'(1);
         total_ff[rd_data_ff.dir] <= total_ff[rd_data_ff.dir]
                                     + swvf_pkg::SUM_BITS'(rd_data_ff.conf);
      end
   end

   // Winner: more votes, then larger sum, then lower direction.
   always_comb begin
      best_in = '0;
      for (int d = 1; d < swvf_pkg::DIR_COUNT; d++) begin
         if (tally_ff[d] > tally_ff[best_in] ||
             (tally_ff[d] == tally_ff[best_in] && total_ff[d] > total_ff[best_in])) begin
            best_in = swvf_pkg::DIR_BITS'(d);
         end
      end
   end

   // Restoring divider step: one quotient bit per cycle.
   always_comb begin
      div_shift = {div_rem_ff, div_quo_ff[swvf_pkg::SUM_BITS-1]};
      div_diff  = div_shift - {1'b0, best_votes_ff};
      div_ge    = div_shift >= {1'b0, best_votes_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         best_dir_ff   <= best_in;
         best_votes_ff <= tally_ff[best_in];
         stable_ff     <= (best_in != '0) && (tally_ff[best_in] >= min_votes_ff);
         div_quo_ff    <= total_ff[best_in];
         div_rem_ff    <= '0;
      end else if (cmd.div_step) begin
         div_quo_ff <= {div_quo_ff[swvf_pkg::SUM_BITS-2:0], div_ge};
         div_rem_ff <= div_ge ? div_diff[swvf_pkg::CNT_BITS-1:0]
                              : div_shift[swvf_pkg::CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.winner_direction <= best_dir_ff;
         rsp_ff.winner_votes     <= best_votes_ff;
         rsp_ff.is_stable        <= stable_ff;
         rsp_ff.mean_confidence  <= (best_votes_ff == '0) ? '0
                                    : div_quo_ff[swvf_pkg::CONF_BITS-1:0];
      end
   end

   assign status.fill = fill_ff;
   assign rsp_data    = rsp_ff;

   `SWVF_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= swvf_pkg::CNT_BITS'(swvf_pkg::WINDOW_MAX))
   `SWVF_ASSERT_NXT(a_winner_votes, clock, reset, cmd.pick, (best_dir_ff == '0) == (best_votes_ff == '0))
   `SWVF_ASSERT_IMP(a_rem_bound, clock, reset, cmd.div_step && best_votes_ff != '0, div_rem_ff < best_votes_ff)

endmodule

>>> sv/swvf_controller.sv
// Sequencer of the vote filter: steps each request through write, tally, pick and divide.
// Depends on swvf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sliding_window_vote_filter_top_assert.svh"

module swvf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  swvf_pkg::status_type status,
   output swvf_pkg::cmd_type    cmd
);

   swvf_pkg::state_type             state_ff;
   swvf_pkg::state_type             state_in;
   logic [swvf_pkg::CNT_BITS-1:0]   cnt_ff;
   logic [swvf_pkg::CNT_BITS-1:0]   cnt_in;
   logic                            rsp_valid_ff;
   logic                            out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swvf_pkg::ST_IDLE: begin
            if (req_valid) state_in = swvf_pkg::ST_WRITE;
         end
         swvf_pkg::ST_WRITE:  state_in = swvf_pkg::ST_TALLY;
         swvf_pkg::ST_TALLY: begin
            if (cnt_ff + swvf_pkg::CNT_BITS'(1) >= status.fill) state_in = swvf_pkg::ST_SETTLE;
         end
         swvf_pkg::ST_SETTLE: state_in = swvf_pkg::ST_PICK;
         swvf_pkg::ST_PICK:   state_in = swvf_pkg::ST_DIVIDE;
         swvf_pkg::ST_DIVIDE: begin
            if (cnt_ff == swvf_pkg::CNT_BITS'(swvf_pkg::DIV_STEPS - 1)) begin
               state_in = swvf_pkg::ST_FINISH;
            end
         end
         swvf_pkg::ST_FINISH: begin
            if (out_free) state_in = swvf_pkg::ST_IDLE;
         end
         default: state_in = swvf_pkg::ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd        = '0;
      cmd.rd_idx = cnt_ff[swvf_pkg::PTR_BITS-1:0];
      req_ready  = 1'b0;
      case (state_ff)
         swvf_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         swvf_pkg::ST_WRITE:  cmd.commit   = 1'b1;
         swvf_pkg::ST_TALLY:  cmd.read     = cnt_ff < status.fill;
         swvf_pkg::ST_PICK:   cmd.pick     = 1'b1;
         swvf_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         swvf_pkg::ST_FINISH: cmd.load_out = out_free;
         default: ;
      endcase
   end

   // Step counter: tally index, then divide step.
   always_comb begin
      case (state_ff)
         swvf_pkg::ST_TALLY,
         swvf_pkg::ST_DIVIDE: cnt_in = cnt_ff + swvf_pkg::CNT_BITS'(1);
         default:             cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swvf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SWVF_ASSERT_NXT(a_accept_writes, clock, reset, req_valid && req_ready, state_ff == swvf_pkg::ST_WRITE)
   `SWVF_ASSERT_IMP(a_tally_range, clock, reset, state_ff == swvf_pkg::ST_TALLY && cnt_ff != '0, cnt_ff < status.fill)
   `SWVF_ASSERT_IMP(a_load_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)

endmodule

>>> sv/sliding_window_vote_filter_top.sv
// Sliding window vote filter, top level; instantiates swvf_controller and swvf_datapath,
// uses swvf_pkg. Each request either adds a vote (direction 0..3, Q0.16 confidence) to a
// ring of the most recent window_length votes or clears the window, and yields exactly
// one response: the direction with most votes (ties to larger confidence sum, then lower
// direction), its count, a stable flag and the truncated mean confidence. Requests are
// handled one at a time: a request passes through a write, a tally (one ring read per
// held vote, fill up to 16), a settle, a pick, a divide (one quotient bit per cycle) and
// an output load, which waits while a previous response still waits for rsp_ready.
// req_ready rises in the same cycle as rsp_valid, so a new request is accepted only once
// the previous response is loaded. The response register lets a new request be taken
// while the previous response still waits for rsp_ready. Settings are written through
// csr_we/csr_index/csr_wdata, which the user must do only while no request is in flight
// (the block does not enforce this): index 0 is window_length (reset 5, 0 acts as 1,
// above 16 acts as 16), index 1 is min_votes_stable (reset 3). Reset is synchronous and
// active high; the vote ring needs no clearing pass.
`timescale 1ns / 1ps

module sliding_window_vote_filter_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  swvf_pkg::req_type              req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output swvf_pkg::rsp_type              rsp_data,
   // settings write port
   input  logic                           csr_we,
   input  logic [swvf_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [swvf_pkg::CNT_BITS-1:0]  csr_wdata
);

   // Commands flow from the sequencer to the datapath; the fill level flows back
   // so the sequencer knows how many ring entries to tally.
   swvf_pkg::cmd_type    cmd;
   swvf_pkg::status_type status;

   swvf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath holds the settings, the ring, the per-direction tallies, the winner
   // registers, the shift-subtract divider and the response register.
   swvf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
